>>> rtl/bia_pkg.sv
// Shared types, constants and helpers of the bitmap id allocator.
// Used by the channel interfaces, the bitmap word RAM, the bit finder and the top level.
`default_nettype none

package bia_pkg;

   localparam int ID_COUNT    = 1024;
   localparam int WORD_BITS   = 8;
   localparam int ID_W        = 10;
   localparam int WORD_COUNT  = (ID_COUNT + WORD_BITS - 1) / WORD_BITS;
   localparam int WORD_IDX_W  = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
   localparam int BIT_IDX_W   = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
   localparam int LAST_WORD   = WORD_COUNT - 1;

   typedef logic [WORD_BITS-1:0]  word_type;
   typedef logic [WORD_IDX_W-1:0] word_idx_type;
   typedef logic [BIT_IDX_W-1:0]  bit_idx_type;
   typedef logic [ID_W-1:0]       id_type;

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_FREE,
      S_SCAN,
      S_DONE
   } state_type;

   // Bits of word w that stand for ids below ID_COUNT.
   function automatic word_type valid_mask(input word_idx_type w);
      longint first;
      word_type m;
      first = longint'(w) * longint'(WORD_BITS);
      for (int b = 0; b < WORD_BITS; b++) begin
         m[b] = ((first + longint'(b)) < longint'(ID_COUNT));
      end
      return m;
   endfunction

endpackage

`default_nettype wire

>>> rtl/bia_if.sv
// Valid/ready channel interfaces for allocator requests and responses.
// Depends on bia_pkg for the payload types.
`default_nettype none

interface bia_req_if
   import bia_pkg::*;
   ;
   logic   valid;
   logic   ready;
   op_type op;
   id_type id;

   modport source (output valid, output op, output id, input ready);
   modport sink   (input valid, input op, input id, output ready);
endinterface

interface bia_rsp_if
   import bia_pkg::*;
   ;
   logic       valid;
   logic       ready;
   status_type status;
   id_type     granted_id;

   modport source (output valid, output status, output granted_id, input ready);
   modport sink   (input valid, input status, input granted_id, output ready);
endinterface

`default_nettype wire

>>> rtl/bitmap_id_allocator.sv
// Bitmap id allocator, top level: sequencer, scan cursor and response register.
// Depends on bia_pkg, bia_if, bia_word_ram and bia_bit_find.
//
// Hands out and takes back ids kept as one used bit per id in a RAM of
// WORD_BITS-bit words (1024 ids in 128 words), all free after reset. One
// transaction is worked at a time; req_ch.ready is high only while the sequencer
// is idle, and a finished response waits in its own register so the next request
// can be taken while it is unread. A release reads the word, writes it back and
// loads the response register. An allocate reads and tests N words, where N is
// the number of words scanned from the cursor (1 to 128): the single RAM read
// port delivers one word per cycle to the bit finder, and the scan stops at the
// first word with a free id or at the last word.
`default_nettype none

module bitmap_id_allocator
   import bia_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   bia_req_if.sink   req_ch,
   bia_rsp_if.source rsp_ch
);

   state_type    state_ff, state_in;
   word_idx_type cursor_ff, cursor_in;
   word_idx_type word_ff, word_in;
   bit_idx_type  bit_ff, bit_in;
   status_type   res_status_ff, res_status_in;
   id_type       res_id_ff, res_id_in;
   logic         rsp_valid_ff, rsp_valid_in;
   status_type   rsp_status_ff, rsp_status_in;
   id_type       rsp_id_ff, rsp_id_in;

   logic         ram_rd_en;
   word_idx_type ram_rd_addr;
   word_type     ram_rd_data;
   logic         ram_wr_en;
   word_idx_type ram_wr_addr;
   word_type     ram_wr_data;

   logic         find_found;
   bit_idx_type  find_bit;
   logic [31:0]  grant_full;
   logic         req_out_of_range;
   word_idx_type req_word;
   bit_idx_type  req_bit;

   bia_word_ram u_word_ram (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data)
   );

   bia_bit_find u_bit_find (
      .word     (ram_rd_data),
      .word_idx (word_ff),
      .found    (find_found),
      .bit_idx  (find_bit)
   );

   assign req_out_of_range = (32'(req_ch.id) >= 32'(ID_COUNT));
   assign req_word         = WORD_IDX_W'(32'(req_ch.id) / WORD_BITS);
   assign req_bit          = BIT_IDX_W'(32'(req_ch.id) % WORD_BITS);
   assign grant_full       = 32'(word_ff) * 32'(WORD_BITS) + 32'(find_bit);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cursor_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cursor_ff    <= cursor_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff       <= word_in;
      bit_ff        <= bit_in;
      res_status_ff <= res_status_in;
      res_id_ff     <= res_id_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
   end

   always_comb begin
      state_in      = state_ff;
      cursor_in     = cursor_ff;
      word_in       = word_ff;
      bit_in        = bit_ff;
      res_status_in = res_status_ff;
      res_id_in     = res_id_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = cursor_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = word_ff;
      ram_wr_data   = ram_rd_data;
      req_ch.ready  = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               if (req_ch.op == OP_FREE) begin
                  if (req_out_of_range) begin
                     res_status_in = ST_RANGE;
                     res_id_in     = '0;
                     state_in      = S_DONE;
                  end else begin
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = req_word;
                     word_in     = req_word;
                     bit_in      = req_bit;
                     state_in    = S_FREE;
                  end
               end else begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = cursor_ff;
                  word_in     = cursor_ff;
                  state_in    = S_SCAN;
               end
            end
         end
         S_FREE: begin
            ram_wr_en     = 1'b1;
            ram_wr_data   = ram_rd_data & ~(word_type'(1) << bit_ff);
            cursor_in     = word_ff;
            res_status_in = ST_OK;
            res_id_in     = '0;
            state_in      = S_DONE;
         end
         S_SCAN: begin
            if (find_found) begin
               ram_wr_en     = 1'b1;
               ram_wr_data   = ram_rd_data | (word_type'(1) << find_bit);
               cursor_in     = word_ff;
               res_status_in = ST_OK;
               res_id_in     = grant_full[ID_W-1:0];
               state_in      = S_DONE;
            end else if (32'(word_ff) == 32'(LAST_WORD)) begin
               res_status_in = ST_FULL;
               res_id_in     = '0;
               state_in      = S_DONE;
            end else begin
               // Advance to the next word; its data arrives next cycle.
               ram_rd_en   = 1'b1;
               ram_rd_addr = word_ff + word_idx_type'(1);
               word_in     = word_ff + word_idx_type'(1);
            end
         end
         S_DONE: begin
            // Hold until the response register is free.
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_id_in     = res_id_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.status     = rsp_status_ff;
   assign rsp_ch.granted_id = rsp_id_ff;

endmodule

`default_nettype wire

>>> rtl/bia_word_ram.sv
// Bitmap word memory: one write port, one registered read port.
// Per-word valid bits make every word read as all-free after reset. Depends on bia_pkg.
`default_nettype none

module bia_word_ram
   import bia_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         rd_en,
   input  wire word_idx_type rd_addr,
   output      word_type     rd_data,
   input  wire logic         wr_en,
   input  wire word_idx_type wr_addr,
   input  wire word_type     wr_data
);

   word_type                mem_ff [WORD_COUNT];
   logic [WORD_COUNT-1:0]   written_ff;
   word_type                rd_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
      end else if (wr_en) begin
         written_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Words never written since reset read as all clear.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= written_ff[rd_addr] ? mem_ff[rd_addr] : '0;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/bia_bit_find.sv
// Shared scan unit: finds the lowest free id bit of one bitmap word.
// Depends on bia_pkg for word and bit index types and the valid mask.
`default_nettype none

module bia_bit_find
   import bia_pkg::*;
(
   input  wire word_type     word,
   input  wire word_idx_type word_idx,
   output      logic         found,
   output      bit_idx_type  bit_idx
);

   word_type free_bits;

   assign free_bits = ~word & valid_mask(word_idx);
   assign found     = |free_bits;

   // Walk down so the lowest set bit wins.
   always_comb begin
      bit_idx = '0;
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (free_bits[b]) begin
            bit_idx = BIT_IDX_W'(b);
         end
      end
   end

endmodule

`default_nettype wire

>>> bench/bitmap_id_allocator_test.sv
// Testbench for bitmap_id_allocator: drives request transactions, predicts each response
// from its own copy of the used-id bitmap and scan cursor, and checks what comes back.
// Depends on bia_pkg, bia_if and the allocator RTL.
`default_nettype none

module bitmap_id_allocator_test
   import bia_pkg::*;
   ;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS    = 1280;
   localparam int PRESSURE_AFTER  = 300;
   localparam int PRESSURE_CYCLES = 400;
   localparam int IDLE_LIMIT      = 4000;
   localparam int DRAIN_CYCLES    = 150;

   typedef struct {
      status_type status;
      id_type     granted_id;
   } grant_type;

   class id_grant_scoreboard;
      word_type  used_map [WORD_COUNT];
      int        scan_word;
      grant_type pending_grants [$];
      int        mismatches;
      int        checked;
      int        alloc_count;
      int        full_count;
      int        free_count;

      function new();
         foreach (used_map[w]) used_map[w] = '0;
         scan_word   = 0;
         mismatches  = 0;
         checked     = 0;
         alloc_count = 0;
         full_count  = 0;
         free_count  = 0;
      endfunction

      function int taken_count();
         int n;
         n = 0;
         foreach (used_map[w]) n += $countones(used_map[w]);
         return n;
      endfunction

      // Work out the response of one accepted request and advance the bitmap.
      function void note_request(op_type op, id_type id);
         grant_type g;
         int        w;
         int        b;
         int        hit_bit;
         bit        found;
         g.status     = ST_OK;
         g.granted_id = '0;
         if (op == OP_FREE) begin
            free_count++;
            if (int'(id) >= ID_COUNT) begin
               g.status = ST_RANGE;
            end else begin
               w = int'(id) / WORD_BITS;
               used_map[w][int'(id) % WORD_BITS] = 1'b0;
               scan_word = w;
            end
         end else begin
            alloc_count++;
            found   = 1'b0;
            hit_bit = 0;
            w       = scan_word;
            // scan forward only; words below the cursor are never revisited
            while (!found && w < WORD_COUNT) begin
               for (b = 0; b < WORD_BITS; b++) begin
                  if (!found && !used_map[w][b] && (w * WORD_BITS + b) < ID_COUNT) begin
                     found   = 1'b1;
                     hit_bit = b;
                  end
               end
               if (!found) w++;
            end
            if (found) begin
               used_map[w][hit_bit] = 1'b1;
               scan_word    = w;
               g.granted_id = id_type'(w * WORD_BITS + hit_bit);
            end else begin
               g.status = ST_FULL;
               full_count++;
            end
         end
         pending_grants.push_back(g);
      endfunction

      function void report_mismatch(string what, int expected_value, int actual_value);
         mismatches++;
         if (mismatches <= 10)
            $display("%t mismatch on %s: expected %0d, got %0d", $realtime, what,
                     expected_value, actual_value);
      endfunction

      function void check_response(status_type status, id_type granted_id);
         grant_type g;
         checked++;
         if (pending_grants.size() == 0) begin
            report_mismatch("unexpected response status", -1, int'(status));
         end else begin
            g = pending_grants.pop_front();
            if (status !== g.status)
               report_mismatch("status", int'(g.status), int'(status));
            if (granted_id !== g.granted_id)
               report_mismatch("granted_id", int'(g.granted_id), int'(granted_id));
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   bia_req_if req_ch ();
   bia_rsp_if rsp_ch ();

   bitmap_id_allocator dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   id_grant_scoreboard sb;
   int items_sent = 0;
   int burst_left = 0;
   bit pressure_done = 1'b0;

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // Offer one request and hold it until it is accepted; called at a rising edge.
   task automatic send_request(op_type op, id_type id);
      int gap;
      bit accepted;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_ch.valid <= 1'b1;
      req_ch.op    <= op;
      req_ch.id    <= id;
      do begin
         @(negedge clock);
         accepted = req_ch.ready;
         @(posedge clock);
      end while (!accepted);
      sb.note_request(op, id);
      items_sent++;
   endtask

   // Pick an id that is currently handed out, starting the search at a random point.
   function automatic id_type pick_taken_id();
      int start;
      int cand;
      start = $urandom_range(0, ID_COUNT - 1);
      for (int k = 0; k < ID_COUNT; k++) begin
         cand = (start + k) % ID_COUNT;
         if (sb.used_map[cand / WORD_BITS][cand % WORD_BITS]) return id_type'(cand);
      end
      return id_type'(start);
   endfunction

   task automatic run_random_traffic(int count);
      int target;
      int kind;
      int n;
      target = items_sent + count;
      while (items_sent < target) begin
         kind = $urandom_range(0, 99);
         if (sb.taken_count() > 640 && kind < 40) begin
            // drain: return handed-out ids so the bitmap does not stay full
            n = $urandom_range(1, 16);
            repeat (n) send_request(OP_FREE, pick_taken_id());
         end else if (kind < 45) begin
            n = $urandom_range(1, 12);
            repeat (n) send_request(OP_ALLOC, id_type'($urandom));
         end else if (kind < 75) begin
            send_request(OP_FREE, pick_taken_id());
            n = $urandom_range(0, 3);
            repeat (n) send_request(OP_ALLOC, id_type'($urandom));
         end else if (kind < 88) begin
            // jump the cursor high, then allocate until the tail runs out
            send_request(OP_FREE, id_type'($urandom_range(768, ID_COUNT - 1)));
            n = $urandom_range(1, 48);
            repeat (n) send_request(OP_ALLOC, id_type'($urandom));
         end else begin
            send_request(OP_FREE, id_type'($urandom));
         end
      end
   endtask

   // Response side: stall on a ready pattern that is reloaded at intervals, and once hold off long.
   initial begin : rsp_stall
      logic [15:0] ready_pattern;
      int          pattern_pos;
      rsp_ch.ready <= 1'b0;
      ready_pattern = '1;
      pattern_pos   = 0;
      forever begin
         @(posedge clock);
         if (!pressure_done && sb.checked >= PRESSURE_AFTER) begin
            rsp_ch.ready <= 1'b0;
            repeat (PRESSURE_CYCLES) @(posedge clock);
            pressure_done = 1'b1;
         end
         if (pattern_pos % 64 == 0)
            ready_pattern = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
         rsp_ch.ready <= ready_pattern[pattern_pos % 16];
         pattern_pos++;
      end
   end

   initial begin : rsp_monitor
      forever begin
         @(negedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready)
            sb.check_response(rsp_ch.status, rsp_ch.granted_id);
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(negedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
      $display("bitmap_id_allocator test failed");
      $finish;
   end

   initial begin : stimulus
      sb = new();
      reset        <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.op    <= OP_ALLOC;
      req_ch.id    <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      send_request(OP_ALLOC, '0);
      send_request(OP_ALLOC, 10'h3FF);
      send_request(OP_FREE, 10'd0);
      send_request(OP_ALLOC, 10'h155);
      // releasing a free id still moves the cursor to the last word
      send_request(OP_FREE, 10'd1023);
      repeat (8) send_request(OP_ALLOC, 10'h2AA);
      send_request(OP_ALLOC, '0);
      send_request(OP_FREE, 10'd1023);
      send_request(OP_ALLOC, '0);
      send_request(OP_FREE, 10'd512);
      send_request(OP_ALLOC, '0);
      send_request(OP_FREE, 10'd1);
      send_request(OP_ALLOC, '0);
      send_request(OP_ALLOC, '0);

      run_random_traffic(RANDOM_ITEMS);
      req_ch.valid <= 1'b0;

      while (sb.pending_grants.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("ran %0d requests: %0d allocations (%0d found no free id), %0d releases",
               items_sent, sb.alloc_count, sb.full_count, sb.free_count);
      $display("checked %0d responses, %0d mismatches", sb.checked, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending_grants.size() == 0)
         $display("bitmap_id_allocator test passed");
      else
         $display("bitmap_id_allocator test failed");
      $finish;
   end

endmodule

`default_nettype wire
